// ===== hw/rtl/kcl_pkg.sv =====
// keypad code lock: shared types, codes and constants
// no dependencies; compiled before every other file of the block
`default_nettype none

package kcl_pkg;

   // default code length, the width of one key and the widths of the seconds and csr fields
   localparam int unsigned KCL_CODE_LENGTH = 4;
   localparam int unsigned KEY_W           = 4;
   localparam int unsigned SECONDS_W       = 4;
   localparam int unsigned CSR_INDEX_W     = 2;
   localparam int unsigned CSR_DATA_W      = 4;

   typedef logic [KEY_W-1:0]       key_type;
   typedef logic [SECONDS_W-1:0]   seconds_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   // key codes with a meaning of their own
   localparam key_type KEY_D    = 4'd13;
   localparam key_type KEY_STAR = 4'd14;
   localparam key_type KEY_HASH = 4'd15;

   // register indexes on the csr port
   localparam csr_index_type CSR_OPEN_SECONDS   = 2'd0;
   localparam csr_index_type CSR_DENIED_SECONDS = 2'd1;
   localparam csr_index_type CSR_SAVED_SECONDS  = 2'd2;
   localparam csr_index_type CSR_IDLE_SECONDS   = 2'd3;

   // register values after reset
   localparam seconds_type OPEN_SECONDS_RST   = 4'd5;
   localparam seconds_type DENIED_SECONDS_RST = 4'd2;
   localparam seconds_type SAVED_SECONDS_RST  = 4'd5;
   localparam seconds_type IDLE_SECONDS_RST   = 4'd15;
   localparam seconds_type SECONDS_MAX        = 4'd15;

   // lock state codes as shown on the result channel
   localparam logic [2:0] LS_CLOSED  = 3'd0;
   localparam logic [2:0] LS_OPEN    = 3'd1;
   localparam logic [2:0] LS_DENIED  = 3'd2;
   localparam logic [2:0] LS_VERIFY  = 3'd3;
   localparam logic [2:0] LS_NEWCODE = 3'd4;
   localparam logic [2:0] LS_SAVED   = 3'd5;

   // internal one-hot lock state
   typedef enum logic [5:0] {
      ST_CLOSED  = 6'b000001,
      ST_OPEN    = 6'b000010,
      ST_DENIED  = 6'b000100,
      ST_VERIFY  = 6'b001000,
      ST_NEWCODE = 6'b010000,
      ST_SAVED   = 6'b100000
   } lock_state_type;

   // timer settings handed from the register bank to the engine
   typedef struct packed {
      seconds_type open_seconds;
      seconds_type denied_seconds;
      seconds_type saved_seconds;
      seconds_type idle_seconds;
   } kcl_cfg_type;

   // one result item
   typedef struct packed {
      logic [2:0] lock_state;
      logic       unlocked;
      logic [2:0] keys_entered;
   } kcl_result_type;

   // one-hot state to its shown code
   function automatic logic [2:0] state_code(input lock_state_type s);
      logic [2:0] c;
      case (s)
         ST_CLOSED:  c = LS_CLOSED;
         ST_OPEN:    c = LS_OPEN;
         ST_DENIED:  c = LS_DENIED;
         ST_VERIFY:  c = LS_VERIFY;
         ST_NEWCODE: c = LS_NEWCODE;
         ST_SAVED:   c = LS_SAVED;
         default:    c = LS_CLOSED;
      endcase
      return c;
   endfunction

   // stored code after reset: 2,5,8,0 then zeros for longer codes
   function automatic key_type reset_digit(input int unsigned i);
      key_type d;
      case (i)
         0:       d = 4'd2;
         1:       d = 4'd5;
         2:       d = 4'd8;
         default: d = 4'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/kcl_if.sv =====
// keypad code lock: valid/ready channel interfaces for keys and results
// depends on kcl_pkg
`default_nettype none

// key and tick channel
interface kcl_req_if import kcl_pkg::*; ();
   logic    valid;
   logic    ready;
   logic    mode;
   key_type key_code;

   modport source (output valid, output mode, output key_code, input ready);
   modport sink   (input valid, input mode, input key_code, output ready);
endinterface

// result channel
interface kcl_rsp_if import kcl_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [2:0] lock_state;
   logic       unlocked;
   logic [2:0] keys_entered;

   modport source (output valid, output lock_state, output unlocked, output keys_entered,
                   input ready);
   modport sink   (input valid, input lock_state, input unlocked, input keys_entered,
                   output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/kcl_csr.sv =====
// keypad code lock: timer setting registers behind the csr write port
// depends on kcl_pkg
`default_nettype none

module kcl_csr import kcl_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          csr_we,
   input  wire csr_index_type csr_index,
   input  wire csr_data_type  csr_wdata,
   output kcl_cfg_type        cfg
);

   kcl_cfg_type cfg_ff;
   kcl_cfg_type cfg_in;

   // decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_OPEN_SECONDS:   cfg_in.open_seconds   = csr_wdata;
            CSR_DENIED_SECONDS: cfg_in.denied_seconds = csr_wdata;
            CSR_SAVED_SECONDS:  cfg_in.saved_seconds  = csr_wdata;
            CSR_IDLE_SECONDS:   cfg_in.idle_seconds   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.open_seconds   <= OPEN_SECONDS_RST;
         cfg_ff.denied_seconds <= DENIED_SECONDS_RST;
         cfg_ff.saved_seconds  <= SAVED_SECONDS_RST;
         cfg_ff.idle_seconds   <= IDLE_SECONDS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/kcl_engine.sv =====
// keypad code lock: lock state machine, stored code and new-code buffer
// depends on kcl_pkg; settings come from kcl_csr
`default_nettype none

module kcl_engine import kcl_pkg::*; #(
   parameter int unsigned CODE_LENGTH = KCL_CODE_LENGTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic        mode,
   input  wire key_type     key_code,
   input  wire kcl_cfg_type cfg,
   output kcl_result_type   result
);

   localparam int unsigned IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam int unsigned CNT_W = $clog2(CODE_LENGTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CODE_LENGTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_LENGTH);

   lock_state_type   state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             mis_ff, mis_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   seconds_type      sec_ff, sec_in;
   key_type          stored_ff [CODE_LENGTH];
   key_type          buf_ff [CODE_LENGTH];

   key_type          expect_key;
   logic             mis_new;
   logic             do_check;
   logic             go;
   lock_state_type   go_target;
   logic             buf_we;
   logic             copy_code;
   logic             timer_fire;
   logic [2:0]       shown;

   // next state for one item
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      mis_in     = mis_ff;
      cnt_in     = cnt_ff;
      sec_in     = sec_ff;
      go         = 1'b0;
      go_target  = ST_CLOSED;
      do_check   = 1'b0;
      buf_we     = 1'b0;
      copy_code  = 1'b0;
      expect_key = stored_ff[idx_ff];
      mis_new    = mis_ff | (expect_key != key_code);

      // tick or key handling by the state found
      if (!mode) begin
         if (sec_ff != SECONDS_MAX) begin
            sec_in = sec_ff + 4'd1;
         end
      end else begin
         case (state_ff)
            ST_CLOSED: begin
               if (key_code == KEY_D) begin
                  go        = 1'b1;
                  go_target = ST_VERIFY;
               end else begin
                  do_check = 1'b1;
               end
            end
            ST_VERIFY: begin
               do_check = 1'b1;
            end
            ST_NEWCODE: begin
               if (key_code == KEY_HASH) begin
                  go        = 1'b1;
                  go_target = ST_CLOSED;
               end else if (key_code == KEY_D && cnt_ff == CNT_FULL) begin
                  copy_code = 1'b1;
                  go        = 1'b1;
                  go_target = ST_SAVED;
               end else if (key_code != KEY_STAR && cnt_ff < CNT_FULL) begin
                  buf_we = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end else begin
                  go        = 1'b1;
                  go_target = ST_VERIFY;
               end
            end
            default: ;
         endcase
      end

      // code entry against the stored code
      if (do_check) begin
         if (idx_ff != IDX_LAST) begin
            idx_in = idx_ff + 1'b1;
            mis_in = mis_new;
         end else begin
            go = 1'b1;
            if (mis_new) begin
               go_target = ST_DENIED;
            end else if (state_ff == ST_CLOSED) begin
               go_target = ST_OPEN;
            end else begin
               go_target = ST_NEWCODE;
            end
         end
      end

      // timers of the timed states; keys never touch the count there
      timer_fire = (state_ff == ST_OPEN   && sec_in >= cfg.open_seconds) ||
                   (state_ff == ST_DENIED && sec_in >= cfg.denied_seconds) ||
                   (state_ff == ST_SAVED  && sec_in >= cfg.saved_seconds);
      if (timer_fire) begin
         go        = 1'b1;
         go_target = ST_CLOSED;
      end

      // change of state clears the entry
      if (go) begin
         state_in = go_target;
         idx_in   = '0;
         mis_in   = 1'b0;
         cnt_in   = '0;
         sec_in   = '0;
      end

      // idle timeout in every state
      if (sec_in >= cfg.idle_seconds) begin
         state_in = ST_CLOSED;
         idx_in   = '0;
         mis_in   = 1'b0;
         cnt_in   = '0;
         sec_in   = '0;
      end
   end

   // result fields from the updated state
   always_comb begin
      case (state_in)
         ST_CLOSED, ST_VERIFY: shown = 3'(idx_in);
         ST_NEWCODE:           shown = 3'(cnt_in);
         default:              shown = 3'd0;
      endcase
      result.lock_state   = state_code(state_in);
      result.unlocked     = (state_in == ST_OPEN);
      result.keys_entered = shown;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLOSED;
         idx_ff   <= '0;
         mis_ff   <= 1'b0;
         cnt_ff   <= '0;
         sec_ff   <= '0;
      end else if (step) begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         mis_ff   <= mis_in;
         cnt_ff   <= cnt_in;
         sec_ff   <= sec_in;
      end
   end

   // stored code, loaded from the buffer when a new code is saved
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
            stored_ff[i] <= reset_digit(i);
         end
      end else if (step && copy_code) begin
         for (int unsigned i = 0; i < CODE_LENGTH; i++) begin
            stored_ff[i] <= buf_ff[i];
         end
      end
   end

   // new-code buffer, written one key at a time
   always_ff @(posedge clock) begin
      if (step && buf_we) begin
         buf_ff[cnt_ff[IDX_W-1:0]] <= key_code;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/keypad_code_lock_top.sv =====
// keypad code lock: top level with input register, engine and result register
// depends on kcl_pkg, kcl_if, kcl_csr and kcl_engine
//
//   channel   direction  transfer                     payload
//   req_if    in         valid & ready                mode, key_code
//   rsp_if    out        valid & ready                lock_state, unlocked, keys_entered
//   csr_*     in         csr_we (no wait, no read)    csr_index, csr_wdata
//
// one item per cycle sustained while rsp_if.ready holds; a req transfer reaches its
// result via the input register, then the state update into the result register
// one result per item, in order; a full result register stalls the input register,
// which then drops req_if.ready
// reset is synchronous, active high: state closed, code 2,5,8,0, timers 5/2/5/15 s
`default_nettype none

module keypad_code_lock_top import kcl_pkg::*; #(
   parameter int unsigned CODE_LENGTH = KCL_CODE_LENGTH
) (
   input  wire logic          clock,
   input  wire logic          reset,
   kcl_req_if.sink            req_if,
   kcl_rsp_if.source          rsp_if,
   input  wire logic          csr_we,
   input  wire csr_index_type csr_index,
   input  wire csr_data_type  csr_wdata
);

   logic           in_v_ff, in_v_in;
   logic           in_mode_ff;
   key_type        in_key_ff;
   logic           out_v_ff, out_v_in;
   kcl_result_type out_ff;
   logic           advance;
   logic           req_take;
   kcl_cfg_type    cfg;
   kcl_result_type result;

   // pipeline handshake
   assign advance  = in_v_ff && (!out_v_ff || rsp_if.ready);
   assign req_take = req_if.valid && req_if.ready;
   assign req_if.ready = !in_v_ff || advance;

   always_comb begin
      in_v_in  = req_take || (in_v_ff && !advance);
      out_v_in = advance || (out_v_ff && !rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff <= req_if.mode;
         in_key_ff  <= req_if.key_code;
      end
   end

   // timer settings
   kcl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // lock state machine
   kcl_engine #(
      .CODE_LENGTH (CODE_LENGTH)
   ) u_engine (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .mode     (in_mode_ff),
      .key_code (in_key_ff),
      .cfg      (cfg),
      .result   (result)
   );

   // result register payload
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_if.valid        = out_v_ff;
   assign rsp_if.lock_state   = out_ff.lock_state;
   assign rsp_if.unlocked     = out_ff.unlocked;
   assign rsp_if.keys_entered = out_ff.keys_entered;

endmodule

`default_nettype wire

// ===== hw/rtl/kcl_checker.sv =====
// keypad code lock: port-level checks, bound to the top level
// depends on kcl_pkg and keypad_code_lock_top
`default_nettype none

module kcl_checker import kcl_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [2:0] rsp_lock_state,
   input wire logic       rsp_unlocked,
   input wire logic [2:0] rsp_keys_entered
);

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lock_state) &&
      $stable(rsp_unlocked) && $stable(rsp_keys_entered))
      else $error("stalled result changed");

   // state code in range and unlocked only when open
   a_state_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lock_state <= LS_SAVED) &&
      (rsp_unlocked == (rsp_lock_state == LS_OPEN)))
      else $error("bad lock state or unlocked flag");

   // no entry count in the timed states
   a_timed_no_keys: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_lock_state == LS_OPEN || rsp_lock_state == LS_DENIED ||
      rsp_lock_state == LS_SAVED) |-> rsp_keys_entered == 3'd0)
      else $error("keys counted in a timed state");

endmodule

bind keypad_code_lock_top kcl_checker u_kcl_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_lock_state   (rsp_if.lock_state),
   .rsp_unlocked     (rsp_if.unlocked),
   .rsp_keys_entered (rsp_if.keys_entered)
);

`default_nettype wire
